// ----- rtl/srq_pkg.sv -----
// Shared constants, types and saturation helper for the scaled rotation to quaternion unit.
package srq_pkg;

	localparam int SQ_STAGES = 32;
	localparam int DV_STAGES = 32;

	localparam logic signed [33:0] ONE_Q30    = 34'sd1073741824;
	localparam logic signed [33:0] THRESH_Q30 = 34'sd1073;
	localparam logic [1:0]         Q_FULL     = 2'd2;

	typedef enum logic [1:0] {
		BR_TRACE,
		BR_X,
		BR_Y,
		BR_Z
	} br_t;

	// Classified word handed from the front to the back.
	typedef struct packed {
		logic [32:0]       t;
		logic [2:0][33:0]  num;
		br_t               br;
		logic [2:0][31:0]  nrm;
		logic              degen;
	} class_t;

	typedef struct packed {
		logic [2:0][31:0] scale;
		logic [3:0][31:0] quat;
		logic             degen;
	} result_t;

	// Signed Q2.30 from a quotient magnitude: zero divisor gives zero, clip to int32.
	function automatic logic [31:0] sat_q(input logic neg, input logic [31:0] quo,
		input logic ovf, input logic dz);
		logic [31:0] r;
		if (dz) begin
			r = '0;
		end else if (neg) begin
			if (ovf || (quo > 32'h8000_0000)) r = 32'h8000_0000;
			else r = ~quo + 32'd1;
		end else begin
			if (ovf || quo[31]) r = 32'h7FFF_FFFF;
			else r = quo;
		end
		return r;
	endfunction

endpackage

// ----- rtl/srq_isqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module srq_isqrt import srq_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] radicand,
	output logic [31:0] root
);

	logic [64:0] rem_s  [1:SQ_STAGES];
	logic [31:0] root_s [1:SQ_STAGES];

	for (genvar k = 0; k < SQ_STAGES; k++) begin : g_st
		localparam int B = SQ_STAGES - 1 - k;
		logic [64:0] cur_rem;
		logic [31:0] cur_root;
		logic [64:0] test;
		logic        ge;

		if (k == 0) begin : g_first
			assign cur_rem  = {1'b0, radicand};
			assign cur_root = '0;
		end else begin : g_next
			assign cur_rem  = rem_s[k];
			assign cur_root = root_s[k];
		end

		// Trial (root + 2^B)^2 - root^2
		assign test = ({33'b0, cur_root} << (B + 1)) + (65'd1 << (2 * B));
		assign ge   = cur_rem >= test;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? (cur_rem - test) : cur_rem;
				root_s[k+1] <= ge ? (cur_root | (32'd1 << B)) : cur_root;
			end
		end
	end

	assign root = root_s[SQ_STAGES];

endmodule

// ----- rtl/srq_div.sv -----
// Pipelined restoring divider, 32 quotient bits with overflow and zero-divisor flags.
module srq_div import srq_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [62:0] num,
	input  logic [32:0] den,
	output logic [31:0] quo,
	output logic        ovf,
	output logic        dz
);

	logic [62:0] rem_s [1:DV_STAGES];
	logic [32:0] den_s [1:DV_STAGES];
	logic [31:0] quo_s [1:DV_STAGES];
	logic        ovf_s [1:DV_STAGES];
	logic        dz_s  [1:DV_STAGES];

	for (genvar k = 0; k < DV_STAGES; k++) begin : g_st
		localparam int B = DV_STAGES - 1 - k;
		logic [62:0] cur_rem;
		logic [32:0] cur_den;
		logic [31:0] cur_quo;
		logic        cur_ovf;
		logic        cur_dz;
		logic [63:0] sh;
		logic        ge;

		if (k == 0) begin : g_first
			assign cur_rem = num;
			assign cur_den = den;
			assign cur_quo = '0;
			// Quotient needs more than 32 bits
			assign cur_ovf = {2'b0, num[62:32]} >= den;
			assign cur_dz  = den == '0;
		end else begin : g_next
			assign cur_rem = rem_s[k];
			assign cur_den = den_s[k];
			assign cur_quo = quo_s[k];
			assign cur_ovf = ovf_s[k];
			assign cur_dz  = dz_s[k];
		end

		assign sh = {31'b0, cur_den} << B;
		assign ge = {1'b0, cur_rem} >= sh;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? (cur_rem - sh[62:0]) : cur_rem;
				quo_s[k+1] <= ge ? (cur_quo | (32'd1 << B)) : cur_quo;
				den_s[k+1] <= cur_den;
				ovf_s[k+1] <= cur_ovf;
				dz_s[k+1]  <= cur_dz;
			end
		end
	end

	assign quo = quo_s[DV_STAGES];
	assign ovf = ovf_s[DV_STAGES];
	assign dz  = dz_s[DV_STAGES];

endmodule

// ----- rtl/srq_front.sv -----
// Front: column norms, column normalization and branch classification.
module srq_front import srq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [8:0][31:0] in_m,
	output logic             out_valid,
	output class_t           out_cls
);

	logic v_s1, v_s2, v_s3, v_s68, v_s69;
	logic [SQ_STAGES-1:0] vsq_s;
	logic [DV_STAGES-1:0] vdv_s;

	logic [8:0][31:0] mag_s1, mag_s2, mag_s3;
	logic [8:0]       neg_s1, neg_s2, neg_s3;
	logic [8:0][63:0] sq_s2;
	logic [2:0][63:0] sum_s3;

	logic [8:0][31:0] mag_sq [1:SQ_STAGES];
	logic [8:0]       neg_sq [1:SQ_STAGES];
	logic [2:0][31:0] nrm;
	logic             dgn;

	logic [8:0]       neg_dv [1:DV_STAGES];
	logic [2:0][31:0] nrm_dv [1:DV_STAGES];
	logic             dgn_dv [1:DV_STAGES];
	logic [8:0][31:0] quo;
	logic [8:0]       ovf, dz;

	logic signed [31:0] b_s68 [0:8];
	logic [2:0][31:0]   nrm_s68;
	logic               dgn_s68;
	class_t             cls_s69;
	class_t             cls_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			vsq_s <= '0;
			vdv_s <= '0;
			v_s68 <= 1'b0;
			v_s69 <= 1'b0;
		end else if (en) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			vsq_s <= {vsq_s[SQ_STAGES-2:0], v_s3};
			vdv_s <= {vdv_s[DV_STAGES-2:0], vsq_s[SQ_STAGES-1]};
			v_s68 <= vdv_s[DV_STAGES-1];
			v_s69 <= v_s68;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 9; i++) begin
				neg_s1[i] <= in_m[i][31];
				mag_s1[i] <= in_m[i][31] ? (~in_m[i] + 32'd1) : in_m[i];
				sq_s2[i]  <= {32'b0, mag_s1[i]} * {32'b0, mag_s1[i]};
				b_s68[i]  <= signed'(sat_q(neg_dv[DV_STAGES][i], quo[i], ovf[i], dz[i]));
			end
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			for (int c = 0; c < 3; c++) begin
				sum_s3[c] <= sq_s2[3*c] + sq_s2[3*c+1] + sq_s2[3*c+2];
			end
			mag_s3 <= mag_s2;
			neg_s3 <= neg_s2;

			mag_sq[1] <= mag_s3;
			neg_sq[1] <= neg_s3;
			for (int k = 1; k < SQ_STAGES; k++) begin
				mag_sq[k+1] <= mag_sq[k];
				neg_sq[k+1] <= neg_sq[k];
			end

			neg_dv[1] <= neg_sq[SQ_STAGES];
			nrm_dv[1] <= nrm;
			dgn_dv[1] <= dgn;
			for (int k = 1; k < DV_STAGES; k++) begin
				neg_dv[k+1] <= neg_dv[k];
				nrm_dv[k+1] <= nrm_dv[k];
				dgn_dv[k+1] <= dgn_dv[k];
			end

			nrm_s68 <= nrm_dv[DV_STAGES];
			dgn_s68 <= dgn_dv[DV_STAGES];
			cls_s69 <= cls_d;
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_norm
		srq_isqrt u_sqrt (
			.clk      (clk),
			.en       (en),
			.radicand (sum_s3[c]),
			.root     (nrm[c])
		);
	end

	assign dgn = (nrm[0] == '0) || (nrm[1] == '0) || (nrm[2] == '0);

	for (genvar i = 0; i < 9; i++) begin : g_nrmz
		localparam int C = i / 3;
		srq_div u_div (
			.clk (clk),
			.en  (en),
			.num ({1'b0, mag_sq[SQ_STAGES][i], 30'b0}),
			.den ({1'b0, nrm[C]}),
			.quo (quo[i]),
			.ovf (ovf[i]),
			.dz  (dz[i])
		);
	end

	// Pick the Shepperd branch and the three numerators that go to the divider.
	always_comb begin
		logic signed [33:0] e [0:8];
		logic signed [33:0] t_tr, t_x, t_y, t_z, t_sel;
		for (int i = 0; i < 9; i++) e[i] = 34'(b_s68[i]);
		t_tr = ONE_Q30 + e[0] + e[4] + e[8];
		t_x  = ONE_Q30 + e[0] - e[4] - e[8];
		t_y  = ONE_Q30 + e[4] - e[0] - e[8];
		t_z  = ONE_Q30 + e[8] - e[0] - e[4];
		if (t_tr > THRESH_Q30) begin
			cls_d.br     = BR_TRACE;
			t_sel        = t_tr;
			cls_d.num[0] = e[5] - e[7];
			cls_d.num[1] = e[6] - e[2];
			cls_d.num[2] = e[1] - e[3];
		end else if ((e[0] > e[4]) && (e[0] > e[8])) begin
			cls_d.br     = BR_X;
			t_sel        = t_x;
			cls_d.num[0] = e[3] + e[1];
			cls_d.num[1] = e[2] + e[6];
			cls_d.num[2] = e[5] - e[7];
		end else if (e[4] > e[8]) begin
			cls_d.br     = BR_Y;
			t_sel        = t_y;
			cls_d.num[0] = e[3] + e[1];
			cls_d.num[1] = e[6] - e[2];
			cls_d.num[2] = e[5] + e[7];
		end else begin
			cls_d.br     = BR_Z;
			t_sel        = t_z;
			cls_d.num[0] = e[1] - e[3];
			cls_d.num[1] = e[2] + e[6];
			cls_d.num[2] = e[5] + e[7];
		end
		// Clamp a negative branch value to zero
		cls_d.t     = t_sel[33] ? 33'd0 : t_sel[32:0];
		cls_d.nrm   = nrm_s68;
		cls_d.degen = dgn_s68;
	end

	assign out_valid = v_s69;
	assign out_cls   = cls_s69;

endmodule

// ----- rtl/srq_back.sv -----
// Back: branch root, component divides, saturation and quaternion assembly.
module srq_back import srq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    in_valid,
	input  class_t  in_cls,
	output logic    out_valid,
	output result_t out_res
);

	logic [SQ_STAGES-1:0] vsq_s;
	logic [DV_STAGES-1:0] vdv_s;
	logic                 v_s65;

	logic [2:0][33:0] num_sq [1:SQ_STAGES];
	br_t              br_sq  [1:SQ_STAGES];
	logic [2:0][31:0] nrm_sq [1:SQ_STAGES];
	logic             dgn_sq [1:SQ_STAGES];
	logic [31:0]      root;

	logic [2:0]       neg_dv  [1:DV_STAGES];
	logic [31:0]      half_dv [1:DV_STAGES];
	br_t              br_dv   [1:DV_STAGES];
	logic [2:0][31:0] nrm_dv  [1:DV_STAGES];
	logic             dgn_dv  [1:DV_STAGES];

	logic [2:0]        neg_in;
	logic [2:0][32:0]  mag_in;
	logic [2:0][31:0]  quo;
	logic [2:0]        ovf, dz;
	result_t           res_d, res_s65;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vsq_s <= '0;
			vdv_s <= '0;
			v_s65 <= 1'b0;
		end else if (en) begin
			vsq_s <= {vsq_s[SQ_STAGES-2:0], in_valid};
			vdv_s <= {vdv_s[DV_STAGES-2:0], vsq_s[SQ_STAGES-1]};
			v_s65 <= vdv_s[DV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_sq[1] <= in_cls.num;
			br_sq[1]  <= in_cls.br;
			nrm_sq[1] <= in_cls.nrm;
			dgn_sq[1] <= in_cls.degen;
			for (int k = 1; k < SQ_STAGES; k++) begin
				num_sq[k+1] <= num_sq[k];
				br_sq[k+1]  <= br_sq[k];
				nrm_sq[k+1] <= nrm_sq[k];
				dgn_sq[k+1] <= dgn_sq[k];
			end

			neg_dv[1]  <= neg_in;
			half_dv[1] <= {1'b0, root[31:1]};
			br_dv[1]   <= br_sq[SQ_STAGES];
			nrm_dv[1]  <= nrm_sq[SQ_STAGES];
			dgn_dv[1]  <= dgn_sq[SQ_STAGES];
			for (int k = 1; k < DV_STAGES; k++) begin
				neg_dv[k+1]  <= neg_dv[k];
				half_dv[k+1] <= half_dv[k];
				br_dv[k+1]   <= br_dv[k];
				nrm_dv[k+1]  <= nrm_dv[k];
				dgn_dv[k+1]  <= dgn_dv[k];
			end

			res_s65 <= res_d;
		end
	end

	srq_isqrt u_sqrt (
		.clk      (clk),
		.en       (en),
		.radicand ({1'b0, in_cls.t, 30'b0}),
		.root     (root)
	);

	for (genvar j = 0; j < 3; j++) begin : g_comp
		logic [33:0] n;
		logic [33:0] nm;
		assign n         = num_sq[SQ_STAGES][j];
		assign nm        = ~n + 34'd1;
		assign neg_in[j] = n[33];
		assign mag_in[j] = n[33] ? nm[32:0] : n[32:0];

		// Divisor is twice the root
		srq_div u_div (
			.clk (clk),
			.en  (en),
			.num ({mag_in[j], 30'b0}),
			.den ({root, 1'b0}),
			.quo (quo[j]),
			.ovf (ovf[j]),
			.dz  (dz[j])
		);
	end

	always_comb begin
		logic [31:0] a, b, c, h;
		a = sat_q(neg_dv[DV_STAGES][0], quo[0], ovf[0], dz[0]);
		b = sat_q(neg_dv[DV_STAGES][1], quo[1], ovf[1], dz[1]);
		c = sat_q(neg_dv[DV_STAGES][2], quo[2], ovf[2], dz[2]);
		h = half_dv[DV_STAGES];
		// quat index: 0 x, 1 y, 2 z, 3 w
		unique case (br_dv[DV_STAGES])
			BR_TRACE: res_d.quat = {h, c, b, a};
			BR_X:     res_d.quat = {c, b, a, h};
			BR_Y:     res_d.quat = {b, c, h, a};
			BR_Z:     res_d.quat = {a, h, c, b};
			default:  res_d.quat = '0;
		endcase
		if (dgn_dv[DV_STAGES]) res_d.quat = '0;
		res_d.scale = nrm_dv[DV_STAGES];
		res_d.degen = dgn_dv[DV_STAGES];
	end

	assign out_valid = v_s65;
	assign out_res   = res_s65;

endmodule

// ----- rtl/scaled_rotation_to_quaternion_unit.sv -----
// Decomposes a scaled 3x3 linear transform into per-axis scales and a unit quaternion.
//
// Input channel: drive the nine Q16.16 elements and raise push; a word is taken
// at a clock edge with push high and full low. Result channel: while empty is
// low the oldest result sits on scale_x..degenerate; raise pop to take it.
// A new matrix can be taken every cycle while full is low. A result passes
// through the front (square, sum, 32-stage norm root, 32-stage normalize
// divide, branch select), a two-word middle queue, the back (32-stage branch
// root, 32-stage component divide, final saturation) and a two-word output
// queue before it shows on the result ports.
// When the receiver stops popping, the output queue fills and the back stalls;
// the middle queue then fills and the front stalls, and full rises. Each side
// resumes in the cycle after space opens, so throughput stays one word per cycle
// whenever pop is held high.
// Reset clears all valid flags and both queues; no result is pending after it.
module scaled_rotation_to_quaternion_unit import srq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [31:0] r0c0,
	input  logic signed [31:0] r1c0,
	input  logic signed [31:0] r2c0,
	input  logic signed [31:0] r0c1,
	input  logic signed [31:0] r1c1,
	input  logic signed [31:0] r2c1,
	input  logic signed [31:0] r0c2,
	input  logic signed [31:0] r1c2,
	input  logic signed [31:0] r2c2,
	output logic               empty,
	input  logic               pop,
	output logic [31:0]        scale_x,
	output logic [31:0]        scale_y,
	output logic [31:0]        scale_z,
	output logic signed [31:0] quat_x,
	output logic signed [31:0] quat_y,
	output logic signed [31:0] quat_z,
	output logic signed [31:0] quat_w,
	output logic               degenerate
);

	logic [8:0][31:0] in_m;
	logic             en_f, en_b;
	logic             f_valid, b_valid;
	class_t           f_cls;
	result_t          b_res;

	class_t     mq_q [0:1];
	logic       mq_wr_q, mq_rd_q;
	logic [1:0] mq_cnt_q;
	logic       mq_push, mq_pop, mq_nempty;

	result_t    oq_q [0:1];
	logic       oq_wr_q, oq_rd_q;
	logic [1:0] oq_cnt_q;
	logic       oq_push, oq_pop;
	result_t    head;

	assign in_m = {r2c2, r1c2, r0c2, r2c1, r1c1, r0c1, r2c0, r1c0, r0c0};

	assign en_f = mq_cnt_q != Q_FULL;
	assign en_b = oq_cnt_q != Q_FULL;
	assign full = !en_f;

	srq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en_f),
		.in_valid  (push && en_f),
		.in_m      (in_m),
		.out_valid (f_valid),
		.out_cls   (f_cls)
	);

	// Middle queue between front and back
	assign mq_nempty = mq_cnt_q != 2'd0;
	assign mq_push   = en_f && f_valid;
	assign mq_pop    = en_b && mq_nempty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mq_wr_q  <= 1'b0;
			mq_rd_q  <= 1'b0;
			mq_cnt_q <= 2'd0;
		end else begin
			if (mq_push) mq_wr_q <= ~mq_wr_q;
			if (mq_pop) mq_rd_q <= ~mq_rd_q;
			mq_cnt_q <= mq_cnt_q + {1'b0, mq_push} - {1'b0, mq_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (mq_push) mq_q[mq_wr_q] <= f_cls;
	end

	srq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en_b),
		.in_valid  (mq_nempty),
		.in_cls    (mq_q[mq_rd_q]),
		.out_valid (b_valid),
		.out_res   (b_res)
	);

	// Output queue
	assign oq_push = en_b && b_valid;
	assign oq_pop  = pop && !empty;
	assign empty   = oq_cnt_q == 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= 1'b0;
			oq_rd_q  <= 1'b0;
			oq_cnt_q <= 2'd0;
		end else begin
			if (oq_push) oq_wr_q <= ~oq_wr_q;
			if (oq_pop) oq_rd_q <= ~oq_rd_q;
			oq_cnt_q <= oq_cnt_q + {1'b0, oq_push} - {1'b0, oq_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (oq_push) oq_q[oq_wr_q] <= b_res;
	end

	assign head       = oq_q[oq_rd_q];
	assign scale_x    = head.scale[0];
	assign scale_y    = head.scale[1];
	assign scale_z    = head.scale[2];
	assign quat_x     = signed'(head.quat[0]);
	assign quat_y     = signed'(head.quat[1]);
	assign quat_z     = signed'(head.quat[2]);
	assign quat_w     = signed'(head.quat[3]);
	assign degenerate = head.degen;

endmodule

// ----- tb/scaled_rotation_to_quaternion_unit_test.sv -----
// Self-checking testbench for the scaled rotation to quaternion unit.
`timescale 1ns / 100ps

module scaled_rotation_to_quaternion_unit_test;
	import srq_pkg::*;

	localparam int ITEM_COUNT  = 1850;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_WAIT  = 300;

	typedef struct {
		logic signed [31:0] m [9];
		logic               hold;
	} matrix_t;

	typedef struct {
		logic [31:0] scale [3];
		logic [31:0] quat [4];
		logic        degen;
	} pose_t;

	logic clk, arst_n, push, full, empty, pop;
	logic signed [31:0] r0c0, r1c0, r2c0, r0c1, r1c1, r2c1, r0c2, r1c2, r2c2;
	logic [31:0] scale_x, scale_y, scale_z;
	logic signed [31:0] quat_x, quat_y, quat_z, quat_w;
	logic degenerate;

	matrix_t pending_mats [$];
	pose_t   expected_poses [$];
	int      mismatches, accepted_mats, popped_poses, degen_seen, idle_cycles;
	bit      stim_done;
	int      burst_left, gap_left, pop_phase;

	scaled_rotation_to_quaternion_unit DUT (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] int_sqrt(input logic [63:0] n);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// num * 2^30 / den, toward zero, clipped to int32
	function automatic longint q30_div(input longint num, input logic [63:0] den);
		logic [63:0] mag, quo;
		if (den == 0) return 0;
		mag = (num < 0) ? -num : num;
		quo = (mag << 30) / den;
		if (num < 0) begin
			if (quo > 64'h8000_0000) quo = 64'h8000_0000;
			return -longint'(quo);
		end
		if (quo > 64'h7FFF_FFFF) quo = 64'h7FFF_FFFF;
		return longint'(quo);
	endfunction

	function automatic logic [63:0] branch_root(input longint t);
		if (t < 0) t = 0;
		return int_sqrt(64'(t) << 30);
	endfunction

	function automatic pose_t decompose(input matrix_t x);
		pose_t p;
		longint b [9];
		logic [63:0] nrm [3];
		logic [63:0] s, sum, a;
		longint qx, qy, qz, qw, t, one;
		one = 64'd1 << 30;
		qx = 0; qy = 0; qz = 0; qw = 0;
		p.degen = 1'b0;
		for (int c = 0; c < 3; c++) begin
			sum = 0;
			for (int r = 0; r < 3; r++) begin
				a = (x.m[c*3+r] < 0) ? -longint'(x.m[c*3+r]) : longint'(x.m[c*3+r]);
				sum += a * a;
			end
			nrm[c] = int_sqrt(sum);
			if (nrm[c] == 0) p.degen = 1'b1;
			p.scale[c] = nrm[c][31:0];
		end
		if (!p.degen) begin
			for (int c = 0; c < 3; c++)
				for (int r = 0; r < 3; r++)
					b[c*3+r] = q30_div(longint'(x.m[c*3+r]), nrm[c]);
			// b index = col*3 + row
			t = one + b[0] + b[4] + b[8];
			if (t > 1073) begin
				s = branch_root(t);
				qx = q30_div(b[5] - b[7], s << 1);
				qy = q30_div(b[6] - b[2], s << 1);
				qz = q30_div(b[1] - b[3], s << 1);
				qw = longint'(s >> 1);
			end else if (b[0] > b[4] && b[0] > b[8]) begin
				s = branch_root(one + b[0] - b[4] - b[8]);
				qx = longint'(s >> 1);
				qy = q30_div(b[3] + b[1], s << 1);
				qz = q30_div(b[2] + b[6], s << 1);
				qw = q30_div(b[5] - b[7], s << 1);
			end else if (b[4] > b[8]) begin
				s = branch_root(one + b[4] - b[0] - b[8]);
				qy = longint'(s >> 1);
				qx = q30_div(b[3] + b[1], s << 1);
				qw = q30_div(b[6] - b[2], s << 1);
				qz = q30_div(b[5] + b[7], s << 1);
			end else begin
				s = branch_root(one + b[8] - b[0] - b[4]);
				qz = longint'(s >> 1);
				qw = q30_div(b[1] - b[3], s << 1);
				qx = q30_div(b[2] + b[6], s << 1);
				qy = q30_div(b[5] + b[7], s << 1);
			end
		end
		p.quat[0] = qx[31:0];
		p.quat[1] = qy[31:0];
		p.quat[2] = qz[31:0];
		p.quat[3] = qw[31:0];
		return p;
	endfunction

	function automatic logic signed [31:0] rand_elem(input int mode);
		case (mode)
			0: return $urandom();
			1: return $signed($urandom_range(0, 131072)) - 65536;
			2: return $signed($urandom_range(0, 16)) - 8;
			default: return ($urandom_range(0, 1) ? 32'sd65536 : -32'sd65536);
		endcase
	endfunction

	task automatic queue_mat(input logic signed [31:0] e [9], input logic hold);
		matrix_t x;
		x.m = e;
		x.hold = hold;
		pending_mats = {pending_mats, x};
	endtask

	// Random rotation-like matrix: signed permutation scaled per column, plus noise.
	task automatic queue_rotation(input int noise);
		logic signed [31:0] e [9];
		int perm [3];
		int k, tmp;
		longint sc;
		perm = '{0, 1, 2};
		for (int i = 2; i > 0; i--) begin
			k = $urandom_range(0, i);
			tmp = perm[i]; perm[i] = perm[k]; perm[k] = tmp;
		end
		for (int c = 0; c < 3; c++) begin
			sc = $urandom_range(1, 1 << $urandom_range(0, 22));
			for (int r = 0; r < 3; r++) begin
				e[c*3+r] = $signed($urandom_range(0, 2*noise)) - noise;
				if (r == perm[c])
					e[c*3+r] = 32'(($urandom_range(0, 1) ? sc : -sc) + e[c*3+r]);
			end
		end
		queue_mat(e, 1'b0);
	endtask

	task automatic fill_items();
		logic signed [31:0] e [9];
		logic signed [31:0] ext [6];
		ext = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, -32'sd1, 32'sd1, 32'sd65536};
		// identity, negated identity, ties, zero columns, extremes
		e = '{65536, 0, 0, 0, 65536, 0, 0, 0, 65536}; queue_mat(e, 1'b0);
		e = '{-65536, 0, 0, 0, -65536, 0, 0, 0, -65536}; queue_mat(e, 1'b0);
		e = '{65536, 0, 0, 0, -65536, 0, 0, 0, -65536}; queue_mat(e, 1'b0);
		e = '{-65536, 0, 0, 0, 65536, 0, 0, 0, -65536}; queue_mat(e, 1'b0);
		e = '{-65536, 0, 0, 0, -65536, 0, 0, 0, 65536}; queue_mat(e, 1'b0);
		e = '{0, 0, 0, 0, 65536, 0, 0, 0, 65536}; queue_mat(e, 1'b0);
		e = '{65536, 0, 0, 0, 0, 0, 0, 0, 65536}; queue_mat(e, 1'b1);
		e = '{65536, 0, 0, 0, 65536, 0, 0, 0, 0}; queue_mat(e, 1'b0);
		e = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; queue_mat(e, 1'b0);
		e = '{-65536, 0, 0, 0, -65536, 0, 0, 0, -65536}; queue_mat(e, 1'b0);
		e = '{0, 65536, 0, 65536, 0, 0, 0, 0, 65536}; queue_mat(e, 1'b0);
		e = '{0, 65536, 0, 0, 0, 65536, 65536, 0, 0}; queue_mat(e, 1'b0);
		for (int i = 0; i < 6; i++) begin
			for (int j = 0; j < 9; j++) e[j] = ext[(i + j) % 6];
			queue_mat(e, 1'b0);
		end
		for (int j = 0; j < 9; j++) e[j] = 32'sh8000_0000;
		queue_mat(e, 1'b0);
		for (int j = 0; j < 9; j++) e[j] = 32'sh7FFF_FFFF;
		queue_mat(e, 1'b1);
		// non-orthogonal: all columns equal, then two nearly opposed columns
		e = '{65536, 65536, 65536, 65536, 65536, 65536, 65536, 65536, 65536}; queue_mat(e, 1'b0);
		e = '{65536, 1, 0, -65536, 1, 0, 0, 0, 65536}; queue_mat(e, 1'b0);
		for (int i = 0; i < ITEM_COUNT - 22; i++) begin
			if ($urandom_range(0, 9) < 7) begin
				queue_rotation($urandom_range(0, 1) ? 0 : $urandom_range(1, 3000));
			end else begin
				for (int j = 0; j < 9; j++) e[j] = rand_elem($urandom_range(0, 3));
				queue_mat(e, ($urandom_range(0, 400) == 0));
			end
		end
		stim_done = 1'b1;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (push && !full) begin
				expected_poses = {expected_poses, decompose(pending_mats.pop_front())};
				accepted_mats <= accepted_mats + 1;
			end
			if (push && full) begin
				// hold the current word
			end else if (pending_mats.size() == 0) begin
				push <= 1'b0;
			end else if (pending_mats[0].hold && expected_poses.size() != 0) begin
				push <= 1'b0;
			end else if (gap_left > 0) begin
				push <= 1'b0;
				gap_left <= gap_left - 1;
			end else begin
				{r0c0, r1c0, r2c0, r0c1, r1c1, r2c1, r0c2, r1c2, r2c2} <=
					{pending_mats[0].m[0], pending_mats[0].m[1], pending_mats[0].m[2],
					 pending_mats[0].m[3], pending_mats[0].m[4], pending_mats[0].m[5],
					 pending_mats[0].m[6], pending_mats[0].m[7], pending_mats[0].m[8]};
				push <= 1'b1;
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// monitor and receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		pose_t exp_p;
		logic [31:0] got [8];
		logic [31:0] want [8];
		if (!arst_n) begin
			pop <= 1'b0;
			pop_phase <= 0;
		end else begin
			if (pop && !empty) begin
				popped_poses <= popped_poses + 1;
				got = '{scale_x, scale_y, scale_z, quat_x, quat_y, quat_z, quat_w,
					{31'd0, degenerate}};
				if (expected_poses.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10) $display("unexpected word from DUT");
				end else begin
					exp_p = expected_poses.pop_front();
					if (exp_p.degen) degen_seen <= degen_seen + 1;
					want = '{exp_p.scale[0], exp_p.scale[1], exp_p.scale[2], exp_p.quat[0],
						exp_p.quat[1], exp_p.quat[2], exp_p.quat[3], {31'd0, exp_p.degen}};
					if (got != want) begin
						mismatches <= mismatches + 1;
						if (mismatches < 10)
							for (int f = 0; f < 8; f++)
								if (got[f] != want[f])
									$display("word %0d field %0d: expected %h got %h",
										popped_poses, f, want[f], got[f]);
					end
				end
			end
			pop_phase <= (pop_phase + 1) % 600;
			if (pop_phase < 150) pop <= 1'b1;
			else if (pop_phase < 300) pop <= ($urandom_range(0, 3) != 0);
			else if (pop_phase < 360) pop <= 1'b0;
			else pop <= $urandom_range(0, 1);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		{r0c0, r1c0, r2c0, r0c1, r1c1, r2c1, r0c2, r1c2, r2c2} = '0;
		mismatches = 0; accepted_mats = 0; popped_poses = 0; degen_seen = 0;
		idle_cycles = 0; stim_done = 1'b0;
		fill_items();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		while (!(pending_mats.size() == 0 && expected_poses.size() == 0 && !push)
			&& idle_cycles < STALL_LIMIT)
			@(posedge clk);
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
		end else begin
			repeat (DRAIN_WAIT) @(posedge clk);
			$display("Covered %0d matrices, %0d results, %0d degenerate, under push/pop stalls.",
				accepted_mats, popped_poses, degen_seen);
			if (mismatches == 0 && expected_poses.size() == 0)
				$display("Test completed successfully");
			else
				$display("Test completed with failures");
		end
		$finish;
	end

endmodule
